### rtl/core/i2cras_pkg.sv
// Shared types and codes for the I2C register access sequencer.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package i2cras_pkg;

	// Request opcodes
	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_STEP  = 2'd2;

	// Engine actions
	localparam logic [2:0] ACT_START   = 3'd0;
	localparam logic [2:0] ACT_SEND    = 3'd1;
	localparam logic [2:0] ACT_RD_ACK  = 3'd2;
	localparam logic [2:0] ACT_RD_NACK = 3'd3;
	localparam logic [2:0] ACT_STOP    = 3'd4;
	localparam logic [2:0] ACT_RECOVER = 3'd5;
	localparam logic [2:0] ACT_NONE    = 3'd6;

	// Completion codes
	localparam logic [2:0] RC_OK        = 3'd0;
	localparam logic [2:0] RC_TIMEOUT   = 3'd1;
	localparam logic [2:0] RC_START     = 3'd2;
	localparam logic [2:0] RC_SLAW_NACK = 3'd3;
	localparam logic [2:0] RC_SLAR_NACK = 3'd4;
	localparam logic [2:0] RC_DATA_NACK = 3'd5;

	// Engine status codes (after masking)
	localparam logic [7:0] ST_MASK     = 8'hF8;
	localparam logic [7:0] ST_START    = 8'h08;
	localparam logic [7:0] ST_RESTART  = 8'h10;
	localparam logic [7:0] ST_SLAW_ACK = 8'h18;
	localparam logic [7:0] ST_DATA_ACK = 8'h28;
	localparam logic [7:0] ST_SLAR_ACK = 8'h40;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_START1 = 4'd1,
		PH_SLAW   = 4'd2,
		PH_REG    = 4'd3,
		PH_DATA   = 4'd4,
		PH_START2 = 4'd5,
		PH_SLAR   = 4'd6,
		PH_RX     = 4'd7
	} phase_t;

	typedef struct packed {
		logic [1:0] op;
		logic [6:0] dev_id;
		logic [7:0] reg_ptr;
		logic [7:0] wr_data;
		logic [7:0] length;
		logic [7:0] bus_status;
		logic [7:0] rx_byte;
		logic       timed_out;
	} req_t;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] tx_byte;
		logic       rx_valid;
		logic [7:0] rx_data;
		logic [7:0] rx_index;
		logic       done_res;
		logic [2:0] result_code;
		logic       last;
	} res_t;

endpackage

### rtl/core/i2cras_req_if.sv
// Request channel: valid/ready handshake plus command and engine-status fields.
// Standalone; no package dependency.
`timescale 1ns / 1ps

interface i2cras_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [6:0] dev_id;
	logic [7:0] reg_ptr;
	logic [7:0] wr_data;
	logic [7:0] length;
	logic [7:0] bus_status;
	logic [7:0] rx_byte;
	logic       timed_out;

	modport source (output valid, op, dev_id, reg_ptr, wr_data, length,
		bus_status, rx_byte, timed_out, input ready);
	modport sink (input valid, op, dev_id, reg_ptr, wr_data, length,
		bus_status, rx_byte, timed_out, output ready);
endinterface

### rtl/core/i2cras_rsp_if.sv
// Result channel: valid/ready handshake plus engine action and completion fields.
// Standalone; no package dependency.
`timescale 1ns / 1ps

interface i2cras_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic [7:0] tx_byte;
	logic       rx_valid;
	logic [7:0] rx_data;
	logic [7:0] rx_index;
	logic       done_res;
	logic [2:0] result_code;
	logic       last;

	modport source (output valid, action, tx_byte, rx_valid, rx_data, rx_index,
		done_res, result_code, last, input ready);
	modport sink (input valid, action, tx_byte, rx_valid, rx_data, rx_index,
		done_res, result_code, last, output ready);
endinterface

### rtl/core/i2c_register_access_sequencer_core.sv
// I2C register access sequencer: input register, one-pass sequencing logic,
// two-entry result buffer. Depends on i2cras_pkg, i2cras_req_if, i2cras_rsp_if.
// A request is registered in the input register on accept; once the result
//   buffer has room it is processed and its results are registered there.
// Throughput: one request per cycle while the result port accepts each result;
//   a request that yields STOP plus recover places two results in the buffer.
// Reset (arst_n low, asynchronous): sequencer idle, buffers empty, state zero.
`timescale 1ns / 1ps

module i2c_register_access_sequencer_core
	import i2cras_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	i2cras_req_if.sink  cmd,
	i2cras_rsp_if.source res
);

	// ------------------------------------------------------------------
	// Stage 1: input register
	// ------------------------------------------------------------------
	logic valid_s1;
	req_t req_s1;

	// Two-entry result buffer; entry 0 is the head.
	res_t       out_q [2];
	logic [1:0] cnt_q;

	// Sequencer state
	phase_t     phase_q;
	logic       is_read_q;
	logic [6:0] target_q;
	logic [7:0] pointer_q;
	logic [7:0] wbyte_q;
	logic [7:0] blen_q;
	logic [7:0] bcount_q;

	logic pop;
	logic fire;       // stage-1 request is processed this cycle
	logic cmd_fire;

	assign pop      = res.valid && res.ready;
	// A request may yield two results, so only process into an empty buffer
	// (after this cycle's pop).
	assign fire     = valid_s1 && ((cnt_q == 2'd0) || (cnt_q == 2'd1 && pop));
	assign cmd.ready = !valid_s1 || fire;
	assign cmd_fire = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			req_s1.op         <= cmd.op;
			req_s1.dev_id     <= cmd.dev_id;
			req_s1.reg_ptr    <= cmd.reg_ptr;
			req_s1.wr_data    <= cmd.wr_data;
			req_s1.length     <= cmd.length;
			req_s1.bus_status <= cmd.bus_status;
			req_s1.rx_byte    <= cmd.rx_byte;
			req_s1.timed_out  <= cmd.timed_out;
		end
	end

	// ------------------------------------------------------------------
	// Sequencing logic
	// ------------------------------------------------------------------
	logic [1:0] n_items;
	res_t       r0, r1;
	phase_t     phase_d;
	logic       is_read_d;
	logic [6:0] target_d;
	logic [7:0] pointer_d;
	logic [7:0] wbyte_d;
	logic [7:0] blen_d;
	logic [7:0] bcount_d;

	always_comb begin
		logic [7:0] st;
		logic       do_fail;
		logic [2:0] fcode;
		logic [7:0] cnt_inc;

		st        = req_s1.bus_status & ST_MASK;
		do_fail   = 1'b0;
		fcode     = RC_OK;
		cnt_inc   = bcount_q + 8'd1;
		n_items   = 2'd0;
		r0        = '0;
		r1        = '0;
		phase_d   = phase_q;
		is_read_d = is_read_q;
		target_d  = target_q;
		pointer_d = pointer_q;
		wbyte_d   = wbyte_q;
		blen_d    = blen_q;
		bcount_d  = bcount_q;

		// Single-item defaults: whatever is emitted is the last item.
		r0.last   = 1'b1;

		case (req_s1.op)
			OP_READ, OP_WRITE: begin
				// Commands are dropped while a transaction is running.
				if (phase_q == PH_IDLE) begin
					is_read_d = (req_s1.op == OP_READ);
					target_d  = req_s1.dev_id;
					pointer_d = req_s1.reg_ptr;
					wbyte_d   = req_s1.wr_data;
					blen_d    = req_s1.length;
					bcount_d  = 8'd0;
					phase_d   = PH_START1;
					n_items   = 2'd1;
					r0.action = ACT_START;
				end
			end
			OP_STEP: begin
				if (phase_q != PH_IDLE) begin
					if (req_s1.timed_out) begin
						do_fail = 1'b1;
						fcode   = RC_TIMEOUT;
					end else begin
						case (phase_q)
							PH_START1: begin
								if (st != ST_START && st != ST_RESTART) begin
									do_fail = 1'b1;
									fcode   = RC_START;
								end else begin
									phase_d    = PH_SLAW;
									n_items    = 2'd1;
									r0.action  = ACT_SEND;
									r0.tx_byte = {target_q, 1'b0};
								end
							end
							PH_SLAW: begin
								if (st != ST_SLAW_ACK) begin
									do_fail = 1'b1;
									fcode   = RC_SLAW_NACK;
								end else begin
									phase_d    = PH_REG;
									n_items    = 2'd1;
									r0.action  = ACT_SEND;
									r0.tx_byte = pointer_q;
								end
							end
							PH_REG: begin
								if (st != ST_DATA_ACK) begin
									do_fail = 1'b1;
									fcode   = RC_DATA_NACK;
								end else if (!is_read_q) begin
									phase_d    = PH_DATA;
									n_items    = 2'd1;
									r0.action  = ACT_SEND;
									r0.tx_byte = wbyte_q;
								end else begin
									// repeated START for the read half
									phase_d   = PH_START2;
									n_items   = 2'd1;
									r0.action = ACT_START;
								end
							end
							PH_DATA: begin
								if (st != ST_DATA_ACK) begin
									do_fail = 1'b1;
									fcode   = RC_DATA_NACK;
								end else begin
									phase_d     = PH_IDLE;
									n_items     = 2'd1;
									r0.action   = ACT_STOP;
									r0.done_res = 1'b1;
								end
							end
							PH_START2: begin
								if (st != ST_START && st != ST_RESTART) begin
									do_fail = 1'b1;
									fcode   = RC_START;
								end else begin
									phase_d    = PH_SLAR;
									n_items    = 2'd1;
									r0.action  = ACT_SEND;
									r0.tx_byte = {target_q, 1'b1};
								end
							end
							PH_SLAR: begin
								if (st != ST_SLAR_ACK) begin
									do_fail = 1'b1;
									fcode   = RC_SLAR_NACK;
								end else if (blen_q == 8'd0) begin
									// empty burst: straight to STOP
									phase_d     = PH_IDLE;
									n_items     = 2'd1;
									r0.action   = ACT_STOP;
									r0.done_res = 1'b1;
								end else begin
									bcount_d  = 8'd0;
									phase_d   = PH_RX;
									n_items   = 2'd1;
									// NACK right away for a one-byte burst
									r0.action = (blen_q > 8'd1) ? ACT_RD_ACK : ACT_RD_NACK;
								end
							end
							PH_RX: begin
								bcount_d    = cnt_inc;
								n_items     = 2'd1;
								r0.rx_valid = 1'b1;
								r0.rx_data  = req_s1.rx_byte;
								r0.rx_index = bcount_q;
								if (cnt_inc >= blen_q) begin
									phase_d     = PH_IDLE;
									r0.action   = ACT_STOP;
									r0.done_res = 1'b1;
								end else begin
									// compare in 9 bits: count+2 against length
									r0.action = (({1'b0, cnt_inc} + 9'd1) < {1'b0, blen_q})
										? ACT_RD_ACK : ACT_RD_NACK;
								end
							end
							default: begin
								phase_d = PH_IDLE;
							end
						endcase
					end
				end
			end
			default: ;
		endcase

		// Any failure: STOP, plus recover for a timeout or START failure.
		if (do_fail) begin
			phase_d   = PH_IDLE;
			r0        = '0;
			r0.action = ACT_STOP;
			if (fcode == RC_TIMEOUT || fcode == RC_START) begin
				n_items        = 2'd2;
				r1.action      = ACT_RECOVER;
				r1.done_res    = 1'b1;
				r1.result_code = fcode;
				r1.last        = 1'b1;
			end else begin
				n_items        = 2'd1;
				r0.done_res    = 1'b1;
				r0.result_code = fcode;
				r0.last        = 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// State registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			is_read_q <= 1'b0;
			target_q  <= '0;
			pointer_q <= '0;
			wbyte_q   <= '0;
			blen_q    <= '0;
			bcount_q  <= '0;
		end else if (fire) begin
			phase_q   <= phase_d;
			is_read_q <= is_read_d;
			target_q  <= target_d;
			pointer_q <= pointer_d;
			wbyte_q   <= wbyte_d;
			blen_q    <= blen_d;
			bcount_q  <= bcount_d;
		end
	end

	// ------------------------------------------------------------------
	// Result buffer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (fire) begin
			cnt_q <= n_items;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q[0] <= r0;
			out_q[1] <= r1;
		end else if (pop) begin
			out_q[0] <= out_q[1];
		end
	end

	assign res.valid       = (cnt_q != 2'd0);
	assign res.action      = out_q[0].action;
	assign res.tx_byte     = out_q[0].tx_byte;
	assign res.rx_valid    = out_q[0].rx_valid;
	assign res.rx_data     = out_q[0].rx_data;
	assign res.rx_index    = out_q[0].rx_index;
	assign res.done_res    = out_q[0].done_res;
	assign res.result_code = out_q[0].result_code;
	assign res.last        = out_q[0].last;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result buffer count out of range");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> (out_q[1].last && !out_q[0].last
			&& out_q[1].action == ACT_RECOVER))
		else $error("two-result pair out of order");

	a_pair_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && n_items == 2'd2 |=> phase_q == PH_IDLE)
		else $error("recovery did not return to idle");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.done_res |-> res.last && res.action != ACT_NONE)
		else $error("completion not on final result");

	a_fire_room: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> (cnt_q == 2'd0 || pop))
		else $error("processed request with a full buffer");

endmodule
